### rtl/zipf_content_index_sampler_core_assert.svh
// Assertion macros used by the sampler checker.
`ifndef ZIPF_CONTENT_INDEX_SAMPLER_CORE_ASSERT_SVH
`define ZIPF_CONTENT_INDEX_SAMPLER_CORE_ASSERT_SVH

// same-cycle implication, off during reset
`define ZCIS_ASSERT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, off during reset
`define ZCIS_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

// next-cycle implication, also checked across reset
`define ZCIS_ASSERT_ALWAYS(label, ante, cons, msg) \
  label: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error(msg);

`endif

### rtl/zcis_pkg.sv
// Shared constants and divider handshake types for the Zipf sampler.
package zcis_pkg;

  localparam int MAX_CONTENTS = 4096;
  localparam int IDX_W        = $clog2(MAX_CONTENTS);
  localparam int CNT_W        = IDX_W + 1;
  localparam int FRAC_W       = 32;
  localparam int SUM_W        = FRAC_W + 4;
  localparam int DIV_NUM_W    = 2 * FRAC_W + 1;
  localparam int DIV_DEN_W    = SUM_W;
  localparam int DIV_CNT_W    = $clog2(DIV_NUM_W + 1);
  localparam int COUNT_RESET  = 1024;

  typedef struct packed {
    logic                 start;
    logic [DIV_NUM_W-1:0] num;
    logic [DIV_DEN_W-1:0] den;
  } div_req_t;

  typedef struct packed {
    logic                 done;
    logic [DIV_NUM_W-1:0] quot;
  } div_rsp_t;

endpackage

### rtl/zcis_div.sv
// Radix-2 restoring divider, one quotient bit per cycle.
module zcis_div (
  input  logic              clk,
  input  logic              rst,
  input  zcis_pkg::div_req_t req,
  output zcis_pkg::div_rsp_t rsp
);
  import zcis_pkg::*;

  logic                 busy;
  logic [DIV_CNT_W-1:0] cnt;
  logic [DIV_NUM_W-1:0] numq;
  logic [DIV_DEN_W-1:0] rem;
  logic [DIV_DEN_W-1:0] den;
  logic [DIV_DEN_W:0]   rem_sh;
  logic [DIV_DEN_W:0]   rem_sub;
  logic                 ge;

  assign rem_sh  = {rem, numq[DIV_NUM_W-1]};
  assign ge      = rem_sh >= {1'b0, den};
  assign rem_sub = rem_sh - {1'b0, den};

  assign rsp.done = busy && (cnt == '0);
  assign rsp.quot = numq;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (req.start) begin
      busy <= 1'b1;
      cnt  <= DIV_CNT_W'(DIV_NUM_W);
    end else if (cnt != '0) begin
      cnt <= cnt - 1'b1;
    end else begin
      busy <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      numq <= req.num;
      den  <= req.den;
      rem  <= '0;
    end else if (cnt != '0) begin
      numq <= {numq[DIV_NUM_W-2:0], ge};
      rem  <= ge ? rem_sub[DIV_DEN_W-1:0] : rem_sh[DIV_DEN_W-1:0];
    end
  end

endmodule

### rtl/zipf_content_index_sampler_core.sv
// Zipf (exponent 1) content index sampler: CDF table build and inverse-CDF draw.
//
// Input words arrive on s_* : s_tuser selects the function (0 build, 1 draw),
// s_tdata carries the UQ0.32 random fraction for a draw. Every word yields one
// result word on m_* : m_tdata holds the content index, m_tuser the error flag
// (draw before a table was built for the current count).
// One word is worked on at a time; s_tready is high only when the core is free.
// A draw runs a binary search over the table between accept and m_tvalid, with one
// CDF memory read per search step, the read address formed from the previous step's
// compare. An error word or a single-content draw skips the search; s_tready returns
// high in the same cycle as m_tvalid rises. A build runs a shared bit-serial
// divider 2*count times, with count taken as 1 to 4096.
// The result sits in an output register; while the receiver stalls a new word
// is still accepted, and the core waits with its next result until the register
// is taken. cfg_we writes content_count (reset 1024) and drops the built flag.
// Reset clears control state and the built flag; the table needs no clearing.
module zipf_content_index_sampler_core (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       cfg_we,
  input  logic [zcis_pkg::CNT_W-1:0] cfg_wdata,   // content_count
  input  logic                       s_tvalid,
  output logic                       s_tready,
  input  logic [31:0]                s_tdata,     // [31:0] rand_fraction
  input  logic                       s_tuser,     // [0] func
  output logic                       m_tvalid,
  input  logic                       m_tready,
  output logic [15:0]                m_tdata,     // [11:0] content_index, rest zero
  output logic                       m_tuser      // [0] status
);
  import zcis_pkg::*;

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_SUM  = 3'd1;
  localparam logic [2:0] ST_C0   = 3'd2;
  localparam logic [2:0] ST_CDF  = 3'd3;
  localparam logic [2:0] ST_SRCH = 3'd4;
  localparam logic [2:0] ST_DONE = 3'd5;

  localparam logic [DIV_NUM_W-1:0] ONE_NUM = DIV_NUM_W'(1) << FRAC_W;
  localparam logic [DIV_NUM_W-1:0] SQ_NUM  = DIV_NUM_W'(1) << (2 * FRAC_W);

  logic [FRAC_W-1:0] mem [MAX_CONTENTS];
  logic [FRAC_W-1:0] rdata;
  logic [IDX_W-1:0]  raddr;
  logic              mem_we;
  logic [IDX_W-1:0]  mem_waddr;
  logic [FRAC_W-1:0] mem_wdata;

  logic [2:0]        state, state_next;
  logic [CNT_W-1:0]  count;
  logic [CNT_W-1:0]  n_eff;
  logic [IDX_W-1:0]  n_last;
  logic              built, built_next;
  logic [CNT_W-1:0]  idx, idx_next;
  logic [CNT_W-1:0]  idx_plus1;
  logic [SUM_W-1:0]  hsum, hsum_next;
  logic [FRAC_W-1:0] c0, c0_next;
  logic [FRAC_W-1:0] acc, acc_next;
  logic [IDX_W-1:0]  lo, lo_next, hi, hi_next, mid, mid_next;
  logic [FRAC_W-1:0] frac, frac_next;
  logic [IDX_W-1:0]  res_idx, res_idx_next;
  logic              res_err, res_err_next;

  logic [SUM_W-1:0]  sum_q;
  logic [FRAC_W:0]   cdf_sum;
  logic [FRAC_W-1:0] cdf_sat;
  logic [FRAC_W-1:0] c0_sat;
  logic [DIV_DEN_W-1:0] den_next;
  logic              less;
  logic [IDX_W-1:0]  lo_s, hi_s;
  logic [CNT_W-1:0]  mid_sum;
  logic              out_free;

  div_req_t div_req;
  div_rsp_t div_rsp;

  zcis_div u_div (
    .clk (clk),
    .rst (rst),
    .req (div_req),
    .rsp (div_rsp)
  );

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    rdata <= mem[raddr];
  end

  always_comb begin
    priority if (count == '0) begin
      n_eff = CNT_W'(1);
    end else if (count > CNT_W'(MAX_CONTENTS)) begin
      n_eff = CNT_W'(MAX_CONTENTS);
    end else begin
      n_eff = count;
    end
  end

  assign n_last    = IDX_W'(n_eff - 1'b1);
  assign idx_plus1 = idx + 1'b1;
  assign den_next  = DIV_DEN_W'(idx_plus1) + 1'b1;
  assign sum_q     = hsum + SUM_W'(div_rsp.quot[FRAC_W:0]);
  assign c0_sat    = (div_rsp.quot[DIV_NUM_W-1:FRAC_W] != '0) ? '1 : div_rsp.quot[FRAC_W-1:0];
  assign cdf_sum   = {1'b0, acc} + {1'b0, div_rsp.quot[FRAC_W-1:0]};
  assign cdf_sat   = cdf_sum[FRAC_W] ? '1 : cdf_sum[FRAC_W-1:0];
  assign less      = frac < rdata;
  assign lo_s      = less ? lo : mid + 1'b1;
  assign hi_s      = less ? mid : hi;
  assign mid_sum   = {1'b0, lo_s} + {1'b0, hi_s};
  assign out_free  = !m_tvalid || m_tready;
  assign s_tready  = state == ST_IDLE;

  always_comb begin
    state_next   = state;
    built_next   = built;
    idx_next     = idx;
    hsum_next    = hsum;
    c0_next      = c0;
    acc_next     = acc;
    lo_next      = lo;
    hi_next      = hi;
    mid_next     = mid;
    frac_next    = frac;
    res_idx_next = res_idx;
    res_err_next = res_err;
    div_req      = '0;
    mem_we       = 1'b0;
    mem_waddr    = idx[IDX_W-1:0];
    mem_wdata    = cdf_sat;
    raddr        = mid;
    unique case (state)
      ST_IDLE: begin
        if (s_tvalid) begin
          res_idx_next = '0;
          res_err_next = 1'b0;
          priority if (!s_tuser) begin
            idx_next      = '0;
            hsum_next     = '0;
            div_req.start = 1'b1;
            div_req.num   = ONE_NUM;
            div_req.den   = DIV_DEN_W'(1);
            state_next    = ST_SUM;
          end else if (!built) begin
            res_err_next = 1'b1;
            state_next   = ST_DONE;
          end else if (n_last == '0) begin
            state_next = ST_DONE;
          end else begin
            lo_next    = '0;
            hi_next    = n_last;
            mid_next   = n_last >> 1;
            raddr      = n_last >> 1;
            frac_next  = s_tdata;
            state_next = ST_SRCH;
          end
        end
      end
      ST_SUM: begin
        if (div_rsp.done) begin
          hsum_next     = sum_q;
          div_req.start = 1'b1;
          if (idx_plus1 == n_eff) begin
            div_req.num = SQ_NUM;
            div_req.den = sum_q;
            state_next  = ST_C0;
          end else begin
            idx_next    = idx_plus1;
            div_req.num = ONE_NUM;
            div_req.den = den_next;
          end
        end
      end
      ST_C0: begin
        if (div_rsp.done) begin
          c0_next   = c0_sat;
          acc_next  = c0_sat;
          mem_we    = 1'b1;
          mem_waddr = '0;
          mem_wdata = c0_sat;
          if (n_eff == CNT_W'(1)) begin
            built_next = 1'b1;
            state_next = ST_DONE;
          end else begin
            idx_next      = CNT_W'(1);
            div_req.start = 1'b1;
            div_req.num   = DIV_NUM_W'(c0_sat);
            div_req.den   = DIV_DEN_W'(2);
            state_next    = ST_CDF;
          end
        end
      end
      ST_CDF: begin
        if (div_rsp.done) begin
          acc_next = cdf_sat;
          mem_we   = 1'b1;
          if (idx_plus1 == n_eff) begin
            built_next = 1'b1;
            state_next = ST_DONE;
          end else begin
            idx_next      = idx_plus1;
            div_req.start = 1'b1;
            div_req.num   = DIV_NUM_W'(c0);
            div_req.den   = den_next;
          end
        end
      end
      ST_SRCH: begin
        lo_next = lo_s;
        hi_next = hi_s;
        if (lo_s == hi_s) begin
          res_idx_next = lo_s;
          state_next   = ST_DONE;
        end else begin
          mid_next = mid_sum[CNT_W-1:1];
          raddr    = mid_sum[CNT_W-1:1];
        end
      end
      ST_DONE: begin
        if (out_free) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      built <= 1'b0;
      count <= CNT_W'(COUNT_RESET);
    end else begin
      state <= state_next;
      built <= cfg_we ? 1'b0 : built_next;
      if (cfg_we) begin
        count <= cfg_wdata;
      end
    end
  end

  always_ff @(posedge clk) begin
    idx     <= idx_next;
    hsum    <= hsum_next;
    c0      <= c0_next;
    acc     <= acc_next;
    lo      <= lo_next;
    hi      <= hi_next;
    mid     <= mid_next;
    frac    <= frac_next;
    res_idx <= res_idx_next;
    res_err <= res_err_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (state == ST_DONE && out_free) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_DONE && out_free) begin
      m_tdata <= {(16 - IDX_W)'(0), res_idx};
      m_tuser <= res_err;
    end
  end

endmodule

### rtl/zcis_checker.sv
// Port-level checks for the sampler core, bound to the top level.
`include "zipf_content_index_sampler_core_assert.svh"

module zcis_checker (
  input logic        clk,
  input logic        rst,
  input logic        s_tvalid,
  input logic        s_tready,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [15:0] m_tdata,
  input logic        m_tuser
);

  `ZCIS_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tuser), "result word changed while stalled")
  `ZCIS_ASSERT_NEXT(a_one_at_a_time, s_tvalid && s_tready, !s_tready, "second word taken while busy")
  `ZCIS_ASSERT(a_err_zero_index, m_tvalid && m_tuser, m_tdata == 16'd0, "error word with nonzero index")
  `ZCIS_ASSERT_ALWAYS(a_reset_empty, rst, !m_tvalid, "result valid after reset")

endmodule

bind zipf_content_index_sampler_core zcis_checker u_zcis_checker (.*);

### tb/zipf_content_index_sampler_core_test.sv
// Self-checking stream testbench for the Zipf content index sampler core.
`timescale 1ns / 1ps

module zipf_content_index_sampler_core_test;
  import zcis_pkg::*;

  typedef enum logic {FUNC_BUILD = 1'b0, FUNC_DRAW = 1'b1} func_e;
  typedef enum logic {ST_OK = 1'b0, ST_NOT_BUILT = 1'b1} status_e;

  typedef struct packed {
    logic [IDX_W-1:0] rank;
    status_e          status;
  } rank_word_t;

  localparam logic [FRAC_W-1:0] FRAC_ALL_ONES = '1;
  localparam int CYCLE_LIMIT  = 20000000;
  localparam int DRAIN_CYCLES = 40;
  localparam int HOLD_CYCLES  = 300;

  class zipf_rank_scoreboard;
    logic [FRAC_W-1:0] cdf[MAX_CONTENTS];
    bit                built;
    logic [CNT_W-1:0]  count_reg;
    rank_word_t        expected_ranks[$];
    int                errors;

    function new();
      built     = 1'b0;
      count_reg = CNT_W'(COUNT_RESET);
      errors    = 0;
    endfunction

    function int unsigned active_count();
      int unsigned n;
      n = 32'(count_reg);
      if (n < 1) n = 1;
      if (n > MAX_CONTENTS) n = MAX_CONTENTS;
      return n;
    endfunction

    function void set_count(logic [CNT_W-1:0] value);
      count_reg = value;
      built     = 1'b0;
    endfunction

    function void build_cdf();
      int unsigned  n;
      logic [63:0]  harm;
      logic [63:0]  acc;
      logic [63:0]  c0;
      logic [127:0] quot;
      n    = active_count();
      harm = 64'd0;
      for (int unsigned i = 0; i < n; i++)
        harm += (64'd1 << FRAC_W) / (i + 1);
      quot = (128'd1 << (2 * FRAC_W)) / {64'd0, harm};
      // a single content would give exactly 1.0
      c0 = (quot > FRAC_ALL_ONES) ? {32'd0, FRAC_ALL_ONES} : quot[63:0];
      acc = c0;
      cdf[0] = acc[FRAC_W-1:0];
      for (int unsigned i = 1; i < n; i++) begin
        acc += c0 / (i + 1);
        if (acc > FRAC_ALL_ONES) acc = {32'd0, FRAC_ALL_ONES};
        cdf[i] = acc[FRAC_W-1:0];
      end
      built = 1'b1;
    endfunction

    function rank_word_t predict_rank(func_e func, logic [FRAC_W-1:0] frac);
      rank_word_t  res;
      int unsigned lo;
      int unsigned hi;
      int unsigned mid;
      res.rank   = '0;
      res.status = ST_OK;
      if (func == FUNC_BUILD) begin
        build_cdf();
      end else if (!built) begin
        res.status = ST_NOT_BUILT;
      end else begin
        lo = 0;
        hi = active_count() - 1;
        while (lo < hi) begin
          mid = (lo + hi) >> 1;
          if (frac < cdf[mid]) hi = mid;
          else lo = mid + 1;
        end
        res.rank = lo[IDX_W-1:0];
      end
      return res;
    endfunction

    function void note_word(func_e func, logic [FRAC_W-1:0] frac);
      expected_ranks.push_back(predict_rank(func, frac));
    endfunction

    function int pending();
      return expected_ranks.size();
    endfunction

    task report(string msg);
      $display("MISMATCH at %0t: %s", $realtime, msg);
      errors++;
    endtask

    task check_word(logic [15:0] data, logic status);
      rank_word_t exp_word;
      if (expected_ranks.size() == 0) begin
        report($sformatf("result word with nothing pending: data %0h status %0b", data, status));
        return;
      end
      exp_word = expected_ranks.pop_front();
      if (data !== {{(16 - IDX_W){1'b0}}, exp_word.rank})
        report($sformatf("content_index got %0d expected %0d", data, exp_word.rank));
      if (status !== exp_word.status)
        report($sformatf("status got %0b expected %0b", status, exp_word.status));
    endtask
  endclass

  logic             clk = 1'b0;
  logic             rst;
  logic             cfg_we;
  logic [CNT_W-1:0] cfg_wdata;
  logic             s_tvalid;
  logic             s_tready;
  logic [31:0]      s_tdata;
  logic             s_tuser;
  logic             m_tvalid;
  logic             m_tready;
  logic [15:0]      m_tdata;
  logic             m_tuser;

  zipf_rank_scoreboard sb = new();
  bit                  gaps_on;
  bit                  hold_req;
  int                  cycle_cnt;

  zipf_content_index_sampler_core u_dut (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_wdata(cfg_wdata),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_cnt++;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) sb.check_word(m_tdata, m_tuser);
  end

  // receiver: random stalls, plus one long hold-off on request
  initial begin
    int hold_left;
    m_tready = 1'b0;
    wait (!rst);
    @(negedge clk);
    forever begin
      if (hold_req) begin
        m_tready = 1'b0;
        hold_req = 1'b0;
        hold_left = HOLD_CYCLES;
        while (hold_left > 0) begin
          @(negedge clk);
          hold_left--;
        end
      end else if (gaps_on && $urandom_range(0, 7) == 0) begin
        m_tready = 1'b0;
        repeat ($urandom_range(1, 17)) @(negedge clk);
      end else begin
        m_tready = 1'b1;
        @(negedge clk);
      end
    end
  end

  // called at a falling edge; returns at a falling edge with the word taken
  task automatic send_word(func_e func, logic [31:0] frac);
    s_tvalid = 1'b1;
    s_tuser  = func;
    s_tdata  = frac;
    do @(posedge clk); while (!s_tready);
    sb.note_word(func, frac);
    @(negedge clk);
    if (gaps_on && $urandom_range(0, 3) == 0) begin
      s_tvalid = 1'b0;
      s_tdata  = $urandom;
      repeat ($urandom_range(1, 17)) @(negedge clk);
    end
  endtask

  task automatic wait_drained();
    s_tvalid = 1'b0;
    while (sb.pending() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic write_count(logic [CNT_W-1:0] value);
    wait_drained();
    cfg_we    = 1'b1;
    cfg_wdata = value;
    @(negedge clk);
    cfg_we    = 1'b0;
    cfg_wdata = CNT_W'($urandom);
    sb.set_count(value);
  endtask

  function automatic logic [31:0] pick_fraction();
    int unsigned k;
    k = $urandom_range(0, sb.active_count() - 1);
    case ($urandom_range(0, 9))
      6, 7:    return sb.cdf[k] + $urandom_range(0, 2) - 1;
      8:       return $urandom_range(0, 255);
      9:       return FRAC_ALL_ONES - $urandom_range(0, 1023);
      default: return $urandom;
    endcase
  endfunction

  task automatic run_draws(int num, bit rebuilds);
    for (int i = 0; i < num; i++) begin
      if (rebuilds && $urandom_range(0, 49) == 0) send_word(FUNC_BUILD, $urandom);
      else send_word(FUNC_DRAW, pick_fraction());
    end
  endtask

  initial begin
    rst       = 1'b1;
    cfg_we    = 1'b0;
    cfg_wdata = '0;
    s_tvalid  = 1'b0;
    s_tdata   = '0;
    s_tuser   = 1'b0;
    gaps_on   = 1'b1;
    hold_req  = 1'b0;
    cycle_cnt = 0;
    repeat (5) @(negedge clk);
    rst = 1'b0;

    // draws before any build
    send_word(FUNC_DRAW, 32'h0);
    send_word(FUNC_DRAW, FRAC_ALL_ONES);

    // count of zero acts as one
    write_count('0);
    send_word(FUNC_BUILD, $urandom);
    send_word(FUNC_DRAW, 32'h0);
    send_word(FUNC_DRAW, FRAC_ALL_ONES);
    send_word(FUNC_DRAW, 32'h8000_0000);

    write_count(CNT_W'(1));
    send_word(FUNC_DRAW, 32'h1234_5678);
    send_word(FUNC_BUILD, $urandom);
    send_word(FUNC_DRAW, FRAC_ALL_ONES - 1);
    send_word(FUNC_DRAW, FRAC_ALL_ONES);

    write_count(CNT_W'(2));
    send_word(FUNC_BUILD, $urandom);
    send_word(FUNC_DRAW, sb.cdf[0] - 1);
    send_word(FUNC_DRAW, sb.cdf[0]);
    send_word(FUNC_DRAW, FRAC_ALL_ONES);
    send_word(FUNC_DRAW, 32'h0);

    // above the maximum, clamps to the full table
    write_count('1);
    send_word(FUNC_DRAW, 32'h0);
    send_word(FUNC_BUILD, $urandom);
    send_word(FUNC_DRAW, 32'h0);
    send_word(FUNC_DRAW, FRAC_ALL_ONES);
    send_word(FUNC_DRAW, sb.cdf[0] - 1);
    send_word(FUNC_DRAW, sb.cdf[0]);
    send_word(FUNC_DRAW, sb.cdf[MAX_CONTENTS-2] - 1);
    send_word(FUNC_DRAW, sb.cdf[MAX_CONTENTS-2]);

    hold_req = 1'b1;
    run_draws(300, 1'b0);

    for (int p = 0; p < 6; p++) begin
      gaps_on = (p == 5) ? 1'b0 : ($urandom_range(0, 3) != 0);
      write_count(CNT_W'((p == 2) ? $urandom_range(301, 600) : $urandom_range(3, 300)));
      repeat ($urandom_range(0, 2)) send_word(FUNC_DRAW, $urandom);
      send_word(FUNC_BUILD, $urandom);
      run_draws(170, 1'b1);
    end

    wait_drained();
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
